// ----- hw/rtl/tcf_pkg.sv -----
// tcf_pkg: widths, register indexes, arctangent table and saturation for the
// tilt complementary filter. No dependencies; tcf_cordic and the top level import it.
`default_nettype none

package tcf_pkg;

  // field and register widths
  localparam int SampleW  = 16;
  localparam int AngleW   = 18;
  localparam int TrimW    = 17;
  localparam int WeightW  = 9;
  localparam int GainW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  // datapath widths
  localparam int CordW    = 34;   // cordic x and y
  localparam int AccW     = 26;   // cordic angle accumulator, q16 degrees
  localparam int AtanIdxW = 5;    // table index; the table holds 23 entries
  localparam int MulAW    = 34;
  localparam int MulBW    = 18;
  localparam int ProdW    = 49;   // gyro rate * time * gain
  localparam int GyroW    = 26;   // propagated angle
  localparam int SumW     = 35;   // blend accumulator

  // angle constants
  localparam int AngleLimit = 92160;      // 360 degrees, q8.8
  localparam int Deg180Q8   = 46080;
  localparam int Deg180Q16  = 11796480;
  localparam int ScaleShift = 14;
  localparam int RoundHalf  = 128;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegAngleTrim   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBlendWeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGyroGain    = 2'd2;

  // register reset values
  localparam logic signed [TrimW-1:0] TrimReset   = '0;
  localparam logic [WeightW-1:0]      WeightReset = 9'd251;
  localparam logic [WeightW-1:0]      WeightFull  = 9'd256;
  localparam logic [GainW-1:0]        GainReset   = 16'd32784;

  // control from the sequencer to the cordic unit
  typedef struct packed {
    logic                load;
    logic                step;
    logic [AtanIdxW-1:0] idx;
  } cordic_ctrl_t;

  // atan(2^-i) in q16 degrees, rounded to nearest
  function automatic logic signed [AccW-1:0] atan_q16(input logic [AtanIdxW-1:0] i);
    logic signed [AccW-1:0] r;
    case (i)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117305;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      5'd18:   r = 26'sd14;
      5'd19:   r = 26'sd7;
      5'd20:   r = 26'sd4;
      5'd21:   r = 26'sd2;
      5'd22:   r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // clamp to plus or minus 360 degrees
  function automatic logic signed [AngleW-1:0] sat_angle(input logic signed [SumW-1:0] v);
    logic signed [AngleW-1:0] r;
    if (v > SumW'(AngleLimit)) begin
      r = AngleW'(AngleLimit);
    end else if (v < SumW'(-AngleLimit)) begin
      r = AngleW'(-AngleLimit);
    end else begin
      r = v[AngleW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcf_in_if.sv -----
// tcf_in_if: request channel carrying one imu sample.
// Standalone; widths match tcf_pkg.
`default_nettype none

interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic        [15:0] elapsed_ms;

  modport source (output valid, accel_y, accel_z, gyro_x, elapsed_ms, input ready);
  modport sink   (input valid, accel_y, accel_z, gyro_x, elapsed_ms, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcf_out_if.sv -----
// tcf_out_if: result channel carrying one fused tilt angle.
// Standalone; widths match tcf_pkg.
`default_nettype none

interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] tilt_angle;

  modport source (output valid, tilt_angle, input ready);
  modport sink   (input valid, tilt_angle, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcf_cordic.sv -----
// tcf_cordic: vectoring cordic for atan2(accel_y, accel_z), one micro-rotation
// per step through a shared shift-add unit. Depends on tcf_pkg.
`default_nettype none

module tcf_cordic (
  input  wire                                 clk_i,
  input  tcf_pkg::cordic_ctrl_t               ctrl_i,
  input  wire logic signed [tcf_pkg::SampleW-1:0] accel_y_i,
  input  wire logic signed [tcf_pkg::SampleW-1:0] accel_z_i,
  output logic signed [tcf_pkg::AngleW-1:0]   angle_o
);
  import tcf_pkg::*;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d;
  logic signed [CordW-1:0] x_load, y_load, x_sh, y_sh;
  logic signed [AccW-1:0]  acc_q, acc_d, acc_load, atan_v, acc_rnd;
  logic                    ay_zero_q, az_neg_q, y_pos;

  // scaled start vector, reflected through the origin for a negative z axis
  always_comb begin
    x_load   = CordW'(accel_z_i) <<< ScaleShift;
    y_load   = CordW'(accel_y_i) <<< ScaleShift;
    acc_load = '0;
    if (accel_z_i < 0) begin
      x_load   = -x_load;
      y_load   = -y_load;
      acc_load = (accel_y_i > 0) ? AccW'(Deg180Q16) : AccW'(-Deg180Q16);
    end
  end

  // one micro-rotation
  always_comb begin
    x_sh   = x_q >>> ctrl_i.idx;
    y_sh   = y_q >>> ctrl_i.idx;
    atan_v = atan_q16(ctrl_i.idx);
    y_pos  = !y_q[CordW-1] && (y_q != '0);
    if (y_pos) begin
      x_d   = x_q + y_sh;
      y_d   = y_q - x_sh;
      acc_d = acc_q + atan_v;
    end else begin
      x_d   = x_q - y_sh;
      y_d   = y_q + x_sh;
      acc_d = acc_q - atan_v;
    end
  end

  // vector and angle registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q       <= x_load;
      y_q       <= y_load;
      acc_q     <= acc_load;
      ay_zero_q <= (accel_y_i == '0);
      az_neg_q  <= (accel_z_i < 0);
    end else if (ctrl_i.step) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  // q16 to q8.8 with rounding, zero y axis handled apart
  always_comb begin
    acc_rnd = acc_q + AccW'(RoundHalf);
    if (ay_zero_q) begin
      angle_o = az_neg_q ? AngleW'(Deg180Q8) : '0;
    end else begin
      angle_o = signed'(acc_rnd[AccW-1:8]);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tilt_complementary_filter_unit.sv -----
// tilt_complementary_filter_unit: top level of the imu tilt filter.
// Depends on tcf_pkg, tcf_in_if, tcf_out_if and tcf_cordic.
`default_nettype none

// One request carries accel y/z, gyro x and the elapsed milliseconds; one
// result carries the fused tilt angle in q8.8 degrees plus the trim, clamped
// to plus or minus 360 degrees. After acceptance the cordic unit does one
// micro-rotation per cycle, followed by the gyro and accel multiply states,
// the fuse state and the result state, which loads the result register. The
// single shared multiplier runs the gyro product alongside the first rotations
// and the blend afterwards. The block takes one request at a time; a finished
// result waits in the output register while the next request is accepted and
// worked on, and the sequencer holds in its result state for as long as that
// register is still occupied. Configuration writes are registered and should
// be made only while the block is idle.
module tilt_complementary_filter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  tcf_in_if.sink                                in_i,
  tcf_out_if.source                             out_o,
  input  wire                                   cfg_we_i,
  input  wire logic [tcf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [tcf_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tcf_pkg::*;

  localparam int StepW = $clog2(CORDIC_STEPS);
  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);

  // sequencer codes
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCordic = 3'd1;
  localparam logic [2:0] StMulG   = 3'd2;
  localparam logic [2:0] StMulA   = 3'd3;
  localparam logic [2:0] StFuse   = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [StepW-1:0]           cnt_q, cnt_d;
  logic signed [TrimW-1:0]    trim_q;
  logic [WeightW-1:0]         weight_q, weight_c, weight_inv;
  logic [GainW-1:0]           gain_q;
  logic signed [SampleW-1:0]  gx_q;
  logic [SampleW-1:0]         ms_q;
  logic signed [ProdW-1:0]    prod_q;
  logic signed [GyroW-1:0]    gyro_ang_q, gyro_ang_d;
  logic signed [SumW-1:0]     sum_q, blend_rnd;
  logic signed [AngleW-1:0]   fused_q, out_q, acc_ang;
  logic                       out_valid_q, in_acc, out_free;
  logic signed [MulAW-1:0]    mul_a;
  logic signed [MulBW-1:0]    mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;
  cordic_ctrl_t               cordic_ctrl;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.tilt_angle = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q   <= TrimReset;
      weight_q <= WeightReset;
      gain_q   <= GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAngleTrim:   trim_q   <= signed'(cfg_data_i[TrimW-1:0]);
        RegBlendWeight: weight_q <= cfg_data_i[WeightW-1:0];
        RegGyroGain:    gain_q   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // weight above full scale acts as full scale
  assign weight_c   = (weight_q > WeightFull) ? WeightFull : weight_q;
  assign weight_inv = WeightFull - weight_c;

  // cordic unit
  assign cordic_ctrl.load = in_acc;
  assign cordic_ctrl.step = (state_q == StCordic);
  assign cordic_ctrl.idx  = AtanIdxW'(cnt_q);

  tcf_cordic u_cordic (
    .clk_i     (clk_i),
    .ctrl_i    (cordic_ctrl),
    .accel_y_i (in_i.accel_y),
    .accel_z_i (in_i.accel_z),
    .angle_o   (acc_ang)
  );

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StCordic: begin
        if (cnt_q == '0) begin
          mul_a = MulAW'(gx_q);
          mul_b = signed'(MulBW'(ms_q));
        end else begin
          mul_a = MulAW'(signed'(prod_q[32:0]));
          mul_b = signed'(MulBW'(gain_q));
        end
      end
      StMulG: begin
        mul_a = MulAW'(gyro_ang_q);
        mul_b = signed'(MulBW'(weight_c));
      end
      StMulA: begin
        mul_a = MulAW'(acc_ang);
        mul_b = signed'(MulBW'(weight_inv));
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // gyro propagated angle and blend rounding
  assign gyro_ang_d = GyroW'(fused_q) + GyroW'(signed'(prod_q[ProdW-1:24]));
  assign blend_rnd  = (sum_q + SumW'(RoundHalf)) >>> 8;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gx_q <= in_i.gyro_x;
      ms_q <= in_i.elapsed_ms;
    end
    if (state_q == StCordic) begin
      if (cnt_q == '0 || cnt_q == StepW'(1)) begin
        prod_q <= mul_p[ProdW-1:0];
      end
      if (cnt_q == StepW'(2)) begin
        gyro_ang_q <= gyro_ang_d;
      end
    end
    if (state_q == StMulG) begin
      sum_q <= mul_p[SumW-1:0];
    end
    if (state_q == StMulA) begin
      sum_q <= sum_q + mul_p[SumW-1:0];
    end
    if (state_q == StOut && out_free) begin
      out_q <= sat_angle(SumW'(fused_q) + SumW'(trim_q));
    end
  end

  // stored fused angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fused_q <= '0;
    end else if (state_q == StFuse) begin
      fused_q <= sat_angle(blend_rnd);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StCordic;
          cnt_d   = '0;
        end
      end
      StCordic: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == LastStep) begin
          state_d = StMulG;
        end
      end
      StMulG: state_d = StMulA;
      StMulA: state_d = StFuse;
      StFuse: state_d = StOut;
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // an accepted request starts the rotations and blocks further requests
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StCordic) && (cnt_q == '0) && !in_i.ready)
    else $error("accepted request did not start the cordic sequence");

  // the result register never holds an angle beyond 360 degrees
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q <= AngleW'(AngleLimit)) && (out_q >= AngleW'(-AngleLimit)))
    else $error("result angle out of range");

  // the fused state stays within 360 degrees after every update
  a_fused_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFuse) |=> (fused_q <= AngleW'(AngleLimit))
                          && (fused_q >= AngleW'(-AngleLimit)))
    else $error("fused angle out of range");

  // leaving the result state always loads a valid result
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) && out_free |=> out_valid_q && (state_q == StIdle))
    else $error("result not loaded on completion");

endmodule

`default_nettype wire
